/* rtl/core/wpp_pkg.sv */
// shared types, codes and constants for the wave header parser
`timescale 1ns / 1ps

package wpp_pkg;

  // parse phases
  typedef enum logic [3:0] {
    PH_RIFF      = 4'd0,
    PH_SIZE      = 4'd1,
    PH_WAVE      = 4'd2,
    PH_CHUNK_ID  = 4'd3,
    PH_CHUNK_LEN = 4'd4,
    PH_SKIP      = 4'd5,
    PH_FMT_LEN   = 4'd6,
    PH_FORMAT    = 4'd7,
    PH_CHANNELS  = 4'd8,
    PH_RATE      = 4'd9,
    PH_GAP       = 4'd10,
    PH_BITS      = 4'd11
  } wpp_phase_t;

  // result status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF     = 3'd1;
  localparam logic [2:0] ST_LEN_MISMATCH = 3'd2;
  localparam logic [2:0] ST_NOT_WAVE     = 3'd3;
  localparam logic [2:0] ST_TRUNCATED    = 3'd4;
  localparam logic [2:0] ST_BAD_FMT_LEN  = 3'd5;
  localparam logic [2:0] ST_NOT_PCM      = 3'd6;

  // tags, first byte in the low lane
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;

  localparam logic [31:0] FMT_DATA_LEN    = 32'd16;
  localparam logic [15:0] PCM_FORMAT      = 16'd1;
  localparam logic [32:0] HEADER_CTRL_LEN = 33'd8;
  localparam logic [31:0] FMT_GAP_BYTES   = 32'd6;

  // input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } wpp_in_t;

  // result item
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
  } wpp_out_t;

  // result from the parser to the output register
  typedef struct packed {
    logic     valid;
    wpp_out_t item;
  } wpp_res_t;

endpackage

/* rtl/core/wpp_parse.sv */
// byte-wise header parse state and result generation
`timescale 1ns / 1ps

module wpp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  wpp_pkg::wpp_in_t item,
  input  logic [31:0]      file_length,
  output wpp_pkg::wpp_res_t res
);

  wpp_pkg::wpp_phase_t parse_phase, parse_phase_next;
  logic [1:0]  byte_position, byte_position_next;
  logic [31:0] field_shift, field_shift_next;
  logic [31:0] skip_remaining, skip_remaining_next;
  logic        tag_mismatch, tag_mismatch_next;
  logic [15:0] held_channels, held_channels_next;
  logic [31:0] held_rate, held_rate_next;
  logic        result_given, result_given_next;

  logic [7:0]  b;
  logic [4:0]  lane;
  logic [31:0] field_new;
  logic [31:0] tag_word;
  logic        mismatch_new;
  logic [31:0] skip_dec;
  logic [32:0] total_len;

  assign b    = item.data_byte;
  assign lane = {byte_position, 3'b000};

  // byte merged into the field being gathered
  always_comb begin
    field_new = field_shift;
    field_new[lane +: 8] = field_shift[lane +: 8] | b;
  end

  // tag expected in the current phase
  always_comb begin
    case (parse_phase)
      wpp_pkg::PH_RIFF: tag_word = wpp_pkg::TAG_RIFF;
      wpp_pkg::PH_WAVE: tag_word = wpp_pkg::TAG_WAVE;
      default:          tag_word = wpp_pkg::TAG_FMT;
    endcase
  end

  assign mismatch_new = tag_mismatch | (b != tag_word[lane +: 8]);
  assign skip_dec     = skip_remaining - 32'd1;
  assign total_len    = {1'b0, field_new} + wpp_pkg::HEADER_CTRL_LEN;

  // next state and result
  always_comb begin
    parse_phase_next    = parse_phase;
    byte_position_next  = byte_position;
    field_shift_next    = field_shift;
    skip_remaining_next = skip_remaining;
    tag_mismatch_next   = tag_mismatch;
    held_channels_next  = held_channels;
    held_rate_next      = held_rate;
    result_given_next   = result_given;
    res                 = '0;

    if (accept) begin
      if (item.end_of_stream) begin
        // rearm for the next file, truncation if nothing was reported
        if (!result_given) begin
          res.valid       = 1'b1;
          res.item.status = wpp_pkg::ST_TRUNCATED;
        end
        parse_phase_next    = wpp_pkg::PH_RIFF;
        byte_position_next  = '0;
        field_shift_next    = '0;
        skip_remaining_next = '0;
        tag_mismatch_next   = 1'b0;
        held_channels_next  = '0;
        held_rate_next      = '0;
        result_given_next   = 1'b0;
      end else if (!result_given) begin
        unique case (parse_phase)
          wpp_pkg::PH_RIFF, wpp_pkg::PH_WAVE, wpp_pkg::PH_CHUNK_ID: begin
            tag_mismatch_next  = mismatch_new;
            byte_position_next = byte_position + 2'd1;
            if (byte_position == 2'd3) begin
              byte_position_next = '0;
              field_shift_next   = '0;
              tag_mismatch_next  = 1'b0;
              if (parse_phase == wpp_pkg::PH_CHUNK_ID) begin
                parse_phase_next = mismatch_new ? wpp_pkg::PH_CHUNK_LEN
                                                : wpp_pkg::PH_FMT_LEN;
              end else if (mismatch_new) begin
                res.valid         = 1'b1;
                res.item.status   = (parse_phase == wpp_pkg::PH_RIFF) ?
                                    wpp_pkg::ST_NOT_RIFF : wpp_pkg::ST_NOT_WAVE;
                result_given_next = 1'b1;
              end else begin
                parse_phase_next = (parse_phase == wpp_pkg::PH_RIFF) ?
                                   wpp_pkg::PH_SIZE : wpp_pkg::PH_CHUNK_ID;
              end
            end
          end
          wpp_pkg::PH_SIZE, wpp_pkg::PH_CHUNK_LEN, wpp_pkg::PH_FMT_LEN,
          wpp_pkg::PH_RATE: begin
            field_shift_next   = field_new;
            byte_position_next = byte_position + 2'd1;
            if (byte_position == 2'd3) begin
              byte_position_next = '0;
              field_shift_next   = '0;
              if (parse_phase == wpp_pkg::PH_SIZE) begin
                if (total_len != {1'b0, file_length}) begin
                  res.valid         = 1'b1;
                  res.item.status   = wpp_pkg::ST_LEN_MISMATCH;
                  result_given_next = 1'b1;
                end else begin
                  parse_phase_next = wpp_pkg::PH_WAVE;
                end
              end else if (parse_phase == wpp_pkg::PH_CHUNK_LEN) begin
                skip_remaining_next = field_new;
                parse_phase_next    = (field_new == '0) ? wpp_pkg::PH_CHUNK_ID
                                                        : wpp_pkg::PH_SKIP;
              end else if (parse_phase == wpp_pkg::PH_FMT_LEN) begin
                if (field_new != wpp_pkg::FMT_DATA_LEN) begin
                  res.valid         = 1'b1;
                  res.item.status   = wpp_pkg::ST_BAD_FMT_LEN;
                  result_given_next = 1'b1;
                end else begin
                  parse_phase_next = wpp_pkg::PH_FORMAT;
                end
              end else begin
                held_rate_next      = field_new;
                skip_remaining_next = wpp_pkg::FMT_GAP_BYTES;
                parse_phase_next    = wpp_pkg::PH_GAP;
              end
            end
          end
          wpp_pkg::PH_FORMAT, wpp_pkg::PH_CHANNELS, wpp_pkg::PH_BITS: begin
            field_shift_next   = field_new;
            byte_position_next = byte_position + 2'd1;
            if (byte_position[0]) begin
              byte_position_next = '0;
              field_shift_next   = '0;
              if (parse_phase == wpp_pkg::PH_FORMAT) begin
                if (field_new[15:0] != wpp_pkg::PCM_FORMAT ||
                    field_new[31:16] != 16'd0) begin
                  res.valid         = 1'b1;
                  res.item.status   = wpp_pkg::ST_NOT_PCM;
                  result_given_next = 1'b1;
                end else begin
                  parse_phase_next = wpp_pkg::PH_CHANNELS;
                end
              end else if (parse_phase == wpp_pkg::PH_CHANNELS) begin
                held_channels_next = field_new[15:0];
                parse_phase_next   = wpp_pkg::PH_RATE;
              end else begin
                res.valid              = 1'b1;
                res.item.status        = wpp_pkg::ST_OK;
                res.item.channel_count = held_channels;
                res.item.sample_rate   = held_rate;
                res.item.sample_bits   = field_new[15:0];
                result_given_next      = 1'b1;
              end
            end
          end
          wpp_pkg::PH_SKIP, wpp_pkg::PH_GAP: begin
            skip_remaining_next = skip_dec;
            if (skip_dec == '0) begin
              parse_phase_next = (parse_phase == wpp_pkg::PH_SKIP) ?
                                 wpp_pkg::PH_CHUNK_ID : wpp_pkg::PH_BITS;
            end
          end
          default: begin
            parse_phase_next = parse_phase;
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= wpp_pkg::PH_RIFF;
      byte_position  <= '0;
      field_shift    <= '0;
      skip_remaining <= '0;
      tag_mismatch   <= 1'b0;
      held_channels  <= '0;
      held_rate      <= '0;
      result_given   <= 1'b0;
    end else begin
      parse_phase    <= parse_phase_next;
      byte_position  <= byte_position_next;
      field_shift    <= field_shift_next;
      skip_remaining <= skip_remaining_next;
      tag_mismatch   <= tag_mismatch_next;
      held_channels  <= held_channels_next;
      held_rate      <= held_rate_next;
      result_given   <= result_given_next;
    end
  end

endmodule

/* rtl/core/wav_pcm_header_parser_top.sv */
// top level of the wave pcm header parser
//
//   channel  signals                          payload
//   -------  -------------------------------  ---------------------------
//   in       in_valid, in_ready, in_data      data_byte, end_of_stream
//   out      out_valid, out_ready, out_data   status, channel_count,
//                                             sample_rate, sample_bits
//   cfg      cfg_valid, cfg_ready, cfg_data   file_length
//
// one byte item is taken per cycle while in_ready is high; a result shows on
// out in the cycle after the item that causes it, held in the output register.
// in_ready drops only while a result waits in the output register and
// out_ready is low; the cfg channel is always ready.
// synchronous reset returns the parser to expecting the riff tag and
// clears file_length; no clearing pass is needed.
`timescale 1ns / 1ps

module wav_pcm_header_parser_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wpp_pkg::wpp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output wpp_pkg::wpp_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  logic [31:0]       file_length;
  logic              in_accept;
  wpp_pkg::wpp_res_t res;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      file_length <= cfg_data;
    end
  end

  wpp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .item        (in_data),
    .file_length (file_length),
    .res         (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && res.valid) begin
      out_data <= res.item;
    end
  end

endmodule
